// ===== hw/rtl/bbe_pkg.sv =====
`default_nettype none
package bbe_pkg;

  // channel and pixel widths
  localparam int CH_W  = 16;
  localparam int PIX_W = 3 * CH_W;
  localparam int CFG_W = 11;

  // channel sum of up to nine samples, and of one window column
  localparam int SUM_W = 20;
  localparam int COL_W = 18;

  // reciprocal multiply for the divisors 1, 4, 6 and 9
  localparam int RCP_W    = 24;
  localparam int RCP_SH   = 23;
  localparam int PROD_W   = SUM_W + RCP_W;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    DIV_1,
    DIV_4,
    DIV_6,
    DIV_9
  } div_t;

  // ceil(2^23 / d), exact for every sum the window can produce
  function automatic logic [RCP_W-1:0] recip(input div_t d);
    logic [RCP_W-1:0] r;
    case (d)
      DIV_1:   r = 24'd8388608;
      DIV_4:   r = 24'd2097152;
      DIV_6:   r = 24'd1398102;
      DIV_9:   r = 24'd932068;
      default: r = 24'd8388608;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/box_blur_3x3_edge_avg.sv =====
// a result follows, through the pipeline, the request that completes its window
// (the pixel one row plus one column later in raster order, or a drain request).
// one request per cycle while ready; the row stores take one read and one write per cycle.
// reset clears counters, window, pipeline, result queue; side becomes min(512, MAX_SIDE).
// the row stores are not cleared and need no sweep after reset.
`default_nettype none
module box_blur_3x3_edge_avg
  import bbe_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration: side
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  // request stream
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [PIX_W-1:0] s_axis_tdata,  // in_red, in_green, in_blue
  input  wire logic             s_axis_tuser,  // kind
  // result stream
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,  // out_red, out_green, out_blue
  output logic                  m_axis_tlast   // frame_end
);

  localparam int XW         = $clog2(MAX_SIDE);
  localparam int SW         = $clog2(MAX_SIDE + 1);
  localparam int YW         = $clog2(MAX_SIDE + 2);
  localparam int CMPW       = (SW > CFG_W) ? SW : CFG_W;
  localparam int RESET_SIDE = (MAX_SIDE < 512) ? MAX_SIDE : 512;
  localparam int PW         = FIFO_AW + 1;
  localparam int QW         = PIX_W + 1;

  // geometry and position
  logic [SW-1:0]   side;
  logic [XW-1:0]   side_m1;
  logic [XW-1:0]   x_cnt;
  logic [YW-1:0]   y_cnt;
  logic [CMPW-1:0] cfg_ext;
  logic [CMPW-1:0] cfg_side;

  // request decode
  logic       x_nz;
  logic       drain_ph;
  logic       item_ok;
  logic       take;
  logic       emit;
  logic       last;
  logic       row_top;
  logic       row_bot;
  logic       col_lft;
  logic       col_rgt;
  logic [2:0] nflag;
  div_t       div_code;
  logic       hit_now;

  // stage 1: row store read data
  logic            s1_valid;
  logic            s1_pix;
  logic            s1_emit;
  logic            s1_last;
  logic [XW-1:0]   s1_x;
  logic [2:0]      s1_rm;
  logic [2:0]      s1_cm;
  div_t            s1_div;
  pix_t            s1_data;
  logic            s1_hit;
  pix_t            fwd_older;
  pix_t            fwd_newer;
  pix_t            older_q;
  pix_t            newer_q;
  pix_t            vec [3];
  pix_t            win_regs [6];
  pix_t            elem [3][3];
  logic [COL_W-1:0] colsum_d [3][3];

  // row stores
  pix_t older_mem [MAX_SIDE];
  pix_t newer_mem [MAX_SIDE];

  // stages 2 to 4
  logic              s2_valid;
  logic              s2_last;
  div_t              s2_div;
  logic [COL_W-1:0]  s2_col [3][3];
  logic              s3_valid;
  logic              s3_last;
  div_t              s3_div;
  logic [SUM_W-1:0]  s3_sum [3];
  logic              s4_valid;
  logic              s4_last;
  logic [PROD_W-1:0] s4_prod [3];

  // result queue
  logic [QW-1:0]      fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [PW-1:0]      fifo_cnt;
  logic [PW-1:0]      pend;
  logic               push;
  logic               pop;
  logic               inc;

  // side clamp for a configuration write
  always_comb begin
    cfg_ext = CMPW'(cfg_wdata);
    if (cfg_ext == '0) begin
      cfg_side = CMPW'(1);
    end else if (cfg_ext > CMPW'(MAX_SIDE)) begin
      cfg_side = CMPW'(MAX_SIDE);
    end else begin
      cfg_side = cfg_ext;
    end
  end

  // phase, emit and window edge flags from the position counters
  always_comb begin
    x_nz     = x_cnt != '0;
    drain_ph = y_cnt >= YW'(side);
    item_ok  = s_axis_tuser ? drain_ph : !drain_ph;
    take     = s_axis_tvalid & s_axis_tready & item_ok;
    emit     = (y_cnt >= YW'(2)) | ((y_cnt == YW'(1)) & x_nz);
    last     = (y_cnt == (YW'(side) + YW'(1))) & !x_nz;
    row_top  = x_nz ? (y_cnt >= YW'(2)) : (y_cnt >= YW'(3));
    row_bot  = x_nz ? (y_cnt < YW'(side)) : (y_cnt <= YW'(side));
    col_lft  = x_nz ? (x_cnt != XW'(1)) : (side_m1 != '0);
    col_rgt  = x_nz;
    nflag    = 3'(row_top) + 3'(row_bot) + 3'(col_lft) + 3'(col_rgt);
    case (nflag)
      3'd2:    div_code = DIV_4;
      3'd3:    div_code = DIV_6;
      3'd4:    div_code = DIV_9;
      default: div_code = DIV_1;
    endcase
    hit_now = s1_valid & s1_pix & (s1_x == x_cnt);
  end

  // side register and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      side    <= SW'(RESET_SIDE);
      side_m1 <= XW'(RESET_SIDE - 1);
      x_cnt   <= '0;
      y_cnt   <= '0;
    end else if (cfg_we) begin
      side    <= SW'(cfg_side);
      side_m1 <= XW'(cfg_side - CMPW'(1));
      x_cnt   <= '0;
      y_cnt   <= '0;
    end else if (take) begin
      if (last) begin
        x_cnt <= '0;
        y_cnt <= '0;
      end else if (x_cnt == side_m1) begin
        x_cnt <= '0;
        y_cnt <= y_cnt + YW'(1);
      end else begin
        x_cnt <= x_cnt + XW'(1);
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  // stage 1 payload, with forwarding when the previous request wrote the same column
  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix    <= !s_axis_tuser;
      s1_emit   <= emit;
      s1_last   <= last;
      s1_x      <= x_cnt;
      s1_rm     <= {row_bot, 1'b1, row_top};
      s1_cm     <= {col_rgt, 1'b1, col_lft};
      s1_div    <= div_code;
      s1_data   <= s_axis_tdata;
      s1_hit    <= hit_now;
      fwd_older <= vec[1];
      fwd_newer <= s1_data;
    end
  end

  // row store read
  always_ff @(posedge clk) begin
    if (take) begin
      older_q <= older_mem[x_cnt];
      newer_q <= newer_mem[x_cnt];
    end
  end

  // current column: rows y-2, y-1, y
  always_comb begin
    vec[0] = s1_hit ? fwd_older : older_q;
    vec[1] = s1_hit ? fwd_newer : newer_q;
    vec[2] = s1_pix ? s1_data : '0;
  end

  // row store write back: shift the column down by one row
  always_ff @(posedge clk) begin
    if (s1_valid & s1_pix) begin
      older_mem[s1_x] <= vec[1];
      newer_mem[s1_x] <= s1_data;
    end
  end

  // two previous window columns
  always_ff @(posedge clk) begin
    if (rst || cfg_we || (s1_valid && s1_last)) begin
      for (int i = 0; i < 6; i++) begin
        win_regs[i] <= '0;
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win_regs[r]     <= win_regs[3 + r];
        win_regs[3 + r] <= vec[r];
      end
    end
  end

  // masked column sums per channel
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      elem[0][r] = win_regs[r];
      elem[1][r] = win_regs[3 + r];
      elem[2][r] = vec[r];
    end
    for (int c = 0; c < 3; c++) begin
      for (int n = 0; n < 3; n++) begin
        colsum_d[c][n] = '0;
        for (int r = 0; r < 3; r++) begin
          if (s1_rm[r] && s1_cm[c]) begin
            colsum_d[c][n] = colsum_d[c][n] + COL_W'(elem[c][r][n*CH_W +: CH_W]);
          end
        end
      end
    end
  end

  // stages 2 to 4 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid & s1_emit;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // column sums, window sum, reciprocal multiply
  always_ff @(posedge clk) begin
    s2_last <= s1_last;
    s2_div  <= s1_div;
    s2_col  <= colsum_d;
    s3_last <= s2_last;
    s3_div  <= s2_div;
    for (int n = 0; n < 3; n++) begin
      s3_sum[n] <= SUM_W'(s2_col[0][n]) + SUM_W'(s2_col[1][n]) + SUM_W'(s2_col[2][n]);
    end
    s4_last <= s3_last;
    for (int n = 0; n < 3; n++) begin
      s4_prod[n] <= PROD_W'(s3_sum[n]) * PROD_W'(recip(s3_div));
    end
  end

  // result queue and credit count
  always_comb begin
    push          = s4_valid;
    pop           = m_axis_tvalid & m_axis_tready;
    inc           = take & emit;
    s_axis_tready = pend < PW'(FIFO_DEPTH);
    m_axis_tvalid = fifo_cnt != '0;
    m_axis_tdata  = fifo_mem[rd_ptr][PIX_W-1:0];
    m_axis_tlast  = fifo_mem[rd_ptr][PIX_W];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= {s4_last,
                           s4_prod[2][RCP_SH +: CH_W],
                           s4_prod[1][RCP_SH +: CH_W],
                           s4_prod[0][RCP_SH +: CH_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      pend     <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_cnt <= fifo_cnt + PW'(push) - PW'(pop);
      pend     <= pend + PW'(inc) - PW'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= PW'(FIFO_DEPTH))
    else $error("credit count above queue depth");

  a_queue_covered: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= pend)
    else $error("queue holds results with no credit");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ((fifo_cnt < PW'(FIFO_DEPTH)) || pop))
    else $error("result pushed into a full queue");

  a_column_range: assert property (@(posedge clk) disable iff (rst)
    x_cnt <= side_m1)
    else $error("column counter past the last column");
`endif

endmodule
`default_nettype wire
